// ===== src/mie_pkg.sv =====
// Package for the modular inverse block: beat types and default datapath width.
`timescale 1ns / 1ps

package mie_pkg;

	// Default width of the internal datapath
	localparam int MIE_WIDTH = 32;

	// Width of the payload fields on the channels
	localparam int FIELD_W = 32;

	// One request beat
	typedef struct packed {
		logic [FIELD_W-1:0] value;
		logic [FIELD_W-1:0] modulus;
	} req_beat_t;

	// One response beat
	typedef struct packed {
		logic [FIELD_W-1:0] inverse;
		logic               has_inverse;
		logic [FIELD_W-1:0] divisor;
	} rsp_beat_t;

endpackage

// ===== src/mie_stream_if.sv =====
// Valid/ready stream interface that carries one beat type.
`timescale 1ns / 1ps

interface mie_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/modular_inverse_ext_euclid_top.sv =====
// Modular inverse by the extended Euclidean algorithm on a shared shift-subtract unit.
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-------------
//  req     | in  | value, modulus (32 b unsigned)   | valid/ready
//  rsp     | out | inverse, has_inverse, divisor    | valid/ready
//
// One request is worked at a time; req.ready is high only while the sequencer is idle.
// Each Euclid step is a check, then align and shift-subtract, one quotient bit at a time;
// the steps stay below about 1.44*WIDTH, plus one when value is not below modulus.
// The response sits in an output register, so a new request is taken while it waits.
// Reset clears the sequencer and the response valid; the datapath is not reset.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_top
	import mie_pkg::*;
#(
	parameter int WIDTH = MIE_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	mie_stream_if.sink    req,
	mie_stream_if.source  rsp
);

	localparam int EW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
	localparam int KW = $clog2(WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ALIGN,
		S_SUB,
		S_REDUCE,
		S_FINAL
	} state_t;

	state_t state_q;

	// Euclid registers: remainders, coefficient magnitudes and signs
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] r0_q;
	logic [WIDTH-1:0] r1_q;
	logic [WIDTH-1:0] u0_q;
	logic [WIDTH-1:0] u1_q;
	logic             n0_q;
	logic             n1_q;

	// Shared divider registers: running remainder, aligned divisor, accumulator
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] acc_q;
	logic [KW-1:0]    k_q;

	// Response register
	logic      rsp_valid_q;
	rsp_beat_t rsp_data_q;

	logic             accept;
	logic             grow;
	logic             ge;
	logic [WIDTH-1:0] rem_n;
	logic [WIDTH-1:0] acc_n;
	logic [EW-1:0]    val_ext;
	logic [EW-1:0]    mod_ext;
	logic             has_w;
	logic [WIDTH-1:0] inv_w;
	logic [EW-1:0]    inv_ext;
	logic [EW-1:0]    gcd_ext;
	logic             rsp_free;

	// Bring the input fields to the datapath width
	assign val_ext = EW'(req.data.value);
	assign mod_ext = EW'(req.data.modulus);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && (state_q == S_IDLE);

	// Align: double the divisor while it still fits under the remainder
	assign grow = ({1'b0, rem_q} >= {d_q, 1'b0}) && (k_q != KW'(WIDTH - 1));

	// Subtract: one quotient bit per cycle, accumulating the coefficient alongside
	assign ge    = (rem_q >= d_q);
	assign rem_n = ge ? (rem_q - d_q) : rem_q;
	assign acc_n = ge ? (acc_q + e_q) : acc_q;

	// Final result: the inverse takes the sign of its coefficient into account
	assign has_w   = (r0_q == WIDTH'(1)) && (m_q > WIDTH'(1));
	assign inv_w   = !has_w ? '0 : ((n0_q && (u0_q != '0)) ? (m_q - u0_q) : u0_q);
	assign inv_ext = EW'(inv_w);
	assign gcd_ext = EW'(r0_q);

	assign rsp_free = !rsp_valid_q || rsp.ready;

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			// Load a new response beat, or drop the one just taken
			if ((state_q == S_FINAL) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= (r1_q == '0) ? S_REDUCE : S_ALIGN;
				end
				S_ALIGN: begin
					if (!grow) begin
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					if (k_q == '0) begin
						state_q <= S_CHECK;
					end
				end
				S_REDUCE: begin
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					if (rsp_free) begin
						rsp_data_q.inverse      <= inv_ext[FIELD_W-1:0];
						rsp_data_q.has_inverse  <= has_w;
						rsp_data_q.divisor      <= gcd_ext[FIELD_W-1:0];
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: Euclid steps on the shared shift-subtract unit
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					m_q  <= mod_ext[WIDTH-1:0];
					r0_q <= mod_ext[WIDTH-1:0];
					r1_q <= val_ext[WIDTH-1:0];
					u0_q <= '0;
					u1_q <= WIDTH'(1);
					n0_q <= 1'b0;
					n1_q <= 1'b0;
				end
			end
			S_CHECK: begin
				d_q   <= r1_q;
				e_q   <= u1_q;
				k_q   <= '0;
				rem_q <= r0_q;
				acc_q <= u0_q;
			end
			S_ALIGN: begin
				if (grow) begin
					d_q <= {d_q[WIDTH-2:0], 1'b0};
					e_q <= {e_q[WIDTH-2:0], 1'b0};
					k_q <= k_q + KW'(1);
				end
			end
			S_SUB: begin
				if (k_q == '0) begin
					// Step done: advance the remainder and coefficient pairs
					r0_q <= r1_q;
					r1_q <= rem_n;
					u0_q <= u1_q;
					u1_q <= acc_n;
					n0_q <= n1_q;
					n1_q <= !n1_q;
				end else begin
					rem_q <= rem_n;
					acc_q <= acc_n;
					d_q   <= {1'b0, d_q[WIDTH-1:1]};
					e_q   <= {1'b0, e_q[WIDTH-1:1]};
					k_q   <= k_q - KW'(1);
				end
			end
			S_REDUCE: begin
				// Fold the coefficient magnitude below the modulus
				if (u0_q >= m_q) begin
					u0_q <= u0_q - m_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// ===== src/mie_checker.sv =====
// Port checker for the modular inverse block, bound to the top level.
`timescale 1ns / 1ps

module mie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_inverse,
	input logic        rsp_has_inverse,
	input logic [31:0] rsp_divisor
);

	// Hold a stalled response beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inverse)
			&& $stable(rsp_has_inverse) && $stable(rsp_divisor))
		else $error("stalled response beat changed");

	// An inverse exists only with a unit divisor
	a_has_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_has_inverse |-> rsp_divisor == 32'd1)
		else $error("inverse flagged with divisor other than one");

	// Drop the inverse to zero when none exists
	a_no_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_has_inverse |-> rsp_inverse == 32'd0)
		else $error("nonzero inverse without an inverse");

	// Go busy right after a request beat is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous still in work");

endmodule

bind modular_inverse_ext_euclid_top mie_checker u_mie_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_inverse     (rsp.data.inverse),
	.rsp_has_inverse (rsp.data.has_inverse),
	.rsp_divisor     (rsp.data.divisor)
);
